[rtl/axis_angle_vector_rotate_unit_assert.svh]
// assertion macros used by the checker file
`ifndef AXIS_ANGLE_VECTOR_ROTATE_UNIT_ASSERT_SVH
`define AXIS_ANGLE_VECTOR_ROTATE_UNIT_ASSERT_SVH

// property checked while reset is low
`define AAVR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("aavr assertion failed");

// property checked also during reset
`define AAVR_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("aavr assertion failed");

`endif

[rtl/aavr_pkg.sv]
package aavr_pkg;

   // constants; ONE_Q30 and CORDIC_GAIN are q1.30
   localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [39:0] MAG_LIMIT   = 40'sd4294967295;
   localparam logic signed [66:0] ROUND_HALF  = 67'sd536870912;
   localparam logic signed [39:0] SAT_MAX     = 40'sd2147483647;
   localparam logic signed [39:0] SAT_MIN     = -40'sd2147483648;
   localparam int unsigned        MAX_CELLS   = 30;

   // quadrant codes
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // item travelling down the cordic cells
   typedef struct packed {
      logic              valid;
      logic [1:0]        quad;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic [2:0][31:0]  vec;
      logic [2:0][31:0]  axis;
   } cordic_item_type;

   // finished result leaving the arithmetic stages
   typedef struct packed {
      logic             valid;
      logic [2:0][31:0] rot;
   } result_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic signed [33:0] atan_turn(input int unsigned idx);
      logic signed [33:0] val;
      unique case (idx)
         0:  val = 34'sh20000000;
         1:  val = 34'sh12E4051E;
         2:  val = 34'sh09FB385B;
         3:  val = 34'sh051111D4;
         4:  val = 34'sh028B0D43;
         5:  val = 34'sh0145D7E1;
         6:  val = 34'sh00A2F61E;
         7:  val = 34'sh00517C55;
         8:  val = 34'sh0028BE53;
         9:  val = 34'sh00145F2F;
         10: val = 34'sh000A2F98;
         11: val = 34'sh000517CC;
         12: val = 34'sh00028BE6;
         13: val = 34'sh000145F3;
         14: val = 34'sh0000A2FA;
         15: val = 34'sh0000517D;
         16: val = 34'sh000028BE;
         17: val = 34'sh0000145F;
         18: val = 34'sh00000A30;
         19: val = 34'sh00000518;
         20: val = 34'sh0000028C;
         21: val = 34'sh00000146;
         22: val = 34'sh000000A3;
         23: val = 34'sh00000051;
         24: val = 34'sh00000029;
         25: val = 34'sh00000014;
         26: val = 34'sh0000000A;
         27: val = 34'sh00000005;
         28: val = 34'sh00000003;
         29: val = 34'sh00000001;
         default: val = 34'sh0;
      endcase
      return val;
   endfunction

   // sign extensions
   function automatic logic signed [39:0] ext40(input logic [31:0] v);
      return {{8{v[31]}}, v};
   endfunction

   function automatic logic signed [33:0] ext34(input logic [31:0] v);
      return {{2{v[31]}}, v};
   endfunction

   // q16.16 (or wider) times q1.30, operand clamped, rounded half up
   function automatic logic signed [39:0] mul_q30(input logic signed [39:0] p,
                                                  input logic signed [33:0] w);
      logic signed [32:0] pc;
      logic signed [66:0] prod;
      if (p > MAG_LIMIT) begin
         pc = MAG_LIMIT[32:0];
      end else if (p < -MAG_LIMIT) begin
         pc = -MAG_LIMIT[32:0];
      end else begin
         pc = p[32:0];
      end
      prod = pc * w + ROUND_HALF;
      return {{3{prod[66]}}, prod[66:30]};
   endfunction

endpackage

[rtl/aavr_req_if.sv]
interface aavr_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] vec_x;
   logic [31:0] vec_y;
   logic [31:0] vec_z;
   logic [31:0] axis_x;
   logic [31:0] axis_y;
   logic [31:0] axis_z;
   logic [15:0] angle;

   modport source(output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle,
                  input ready);
   modport sink(input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle,
                output ready);
endinterface

[rtl/aavr_rsp_if.sv]
interface aavr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] rot_x;
   logic [31:0] rot_y;
   logic [31:0] rot_z;

   modport source(output valid, rot_x, rot_y, rot_z, input ready);
   modport sink(input valid, rot_x, rot_y, rot_z, output ready);
endinterface

[rtl/aavr_cordic_cell.sv]
module aavr_cordic_cell #(
   parameter int unsigned SHIFT = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  aavr_pkg::cordic_item_type cell_in,
   output aavr_pkg::cordic_item_type cell_out
);
   import aavr_pkg::*;

   localparam logic signed [33:0] ATAN = atan_turn(SHIFT);

   cordic_item_type item_ff, item_in;
   logic signed [33:0] dx, dy;

   // one micro-rotation, direction from the sign of z
   always_comb begin
      dx      = cell_in.y >>> SHIFT;
      dy      = cell_in.x >>> SHIFT;
      item_in = cell_in;
      if (!cell_in.z[33]) begin
         item_in.x = cell_in.x - dx;
         item_in.y = cell_in.y + dy;
         item_in.z = cell_in.z - ATAN;
      end else begin
         item_in.x = cell_in.x + dx;
         item_in.y = cell_in.y - dy;
         item_in.z = cell_in.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (enable) begin
         item_ff <= item_in;
      end
   end

   assign cell_out = item_ff;
endmodule

[rtl/aavr_combine.sv]
module aavr_combine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  aavr_pkg::cordic_item_type item,
   output aavr_pkg::result_type      result
);
   import aavr_pkg::*;

   logic [5:1] valid_ff;

   // stage 1
   logic signed [39:0] pv_ff [3][3];
   logic signed [31:0] c_ff, s_ff, c_in, s_in;
   logic signed [33:0] cq, sq;
   logic [2:0][31:0]   vec1_ff, axis1_ff;
   // stage 2
   logic signed [39:0] cross_ff [3];
   logic signed [39:0] vc2_ff [3];
   logic signed [39:0] d_ff;
   logic signed [33:0] omc2_ff;
   logic signed [31:0] s2_ff;
   logic [2:0][31:0]   axis2_ff;
   // stage 3
   logic signed [39:0] cs3_ff [3];
   logic signed [39:0] dk3_ff [3];
   logic signed [39:0] vc3_ff [3];
   logic signed [33:0] omc3_ff;
   // stage 4
   logic signed [39:0] dko4_ff [3];
   logic signed [39:0] cs4_ff [3];
   logic signed [39:0] vc4_ff [3];
   // stage 5
   logic [2:0][31:0]   rot_ff, rot_in;
   logic signed [39:0] sum [3];

   // quadrant fold of the cordic output, clamped to +-1.0 in q1.30
   always_comb begin
      unique case (item.quad)
         QUAD_0: begin cq = item.x;  sq = item.y;  end
         QUAD_1: begin cq = -item.y; sq = item.x;  end
         QUAD_2: begin cq = -item.x; sq = -item.y; end
         QUAD_3: begin cq = item.y;  sq = -item.x; end
         default: begin cq = item.x; sq = item.y; end
      endcase
      if (cq > ONE_Q30) c_in = ONE_Q30[31:0];
      else if (cq < -ONE_Q30) c_in = -ONE_Q30[31:0];
      else c_in = cq[31:0];
      if (sq > ONE_Q30) s_in = ONE_Q30[31:0];
      else if (sq < -ONE_Q30) s_in = -ONE_Q30[31:0];
      else s_in = sq[31:0];
   end

   // final sum and saturation
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         sum[j] = vc4_ff[j] + cs4_ff[j] + dko4_ff[j];
         if (sum[j] > SAT_MAX) rot_in[j] = SAT_MAX[31:0];
         else if (sum[j] < SAT_MIN) rot_in[j] = SAT_MIN[31:0];
         else rot_in[j] = sum[j][31:0];
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[4:1], item.valid};
      end
   end

   // product stages
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int j = 0; j < 3; j++) begin
            for (int m = 0; m < 3; m++) begin
               pv_ff[j][m] <= mul_q30(ext40(item.vec[j]), ext34(item.axis[m]));
            end
         end
         c_ff     <= c_in;
         s_ff     <= s_in;
         vec1_ff  <= item.vec;
         axis1_ff <= item.axis;

         cross_ff[0] <= pv_ff[2][1] - pv_ff[1][2];
         cross_ff[1] <= pv_ff[0][2] - pv_ff[2][0];
         cross_ff[2] <= pv_ff[1][0] - pv_ff[0][1];
         d_ff        <= pv_ff[0][0] + pv_ff[1][1] + pv_ff[2][2];
         for (int j = 0; j < 3; j++) begin
            vc2_ff[j] <= mul_q30(ext40(vec1_ff[j]), ext34(c_ff));
         end
         omc2_ff  <= ONE_Q30 - ext34(c_ff);
         s2_ff    <= s_ff;
         axis2_ff <= axis1_ff;

         for (int j = 0; j < 3; j++) begin
            cs3_ff[j] <= mul_q30(cross_ff[j], ext34(s2_ff));
            dk3_ff[j] <= mul_q30(d_ff, ext34(axis2_ff[j]));
            vc3_ff[j] <= vc2_ff[j];
         end
         omc3_ff <= omc2_ff;

         for (int j = 0; j < 3; j++) begin
            dko4_ff[j] <= mul_q30(dk3_ff[j], omc3_ff);
            cs4_ff[j]  <= cs3_ff[j];
            vc4_ff[j]  <= vc3_ff[j];
         end

         rot_ff <= rot_in;
      end
   end

   assign result.valid = valid_ff[5];
   assign result.rot   = rot_ff;
endmodule

[rtl/axis_angle_vector_rotate_unit.sv]
// Rotates a Q16.16 vector about a Q1.30 axis by a 16-bit fraction-of-turn angle
// (Rodrigues' formula), saturating each output. Fully pipelined: one item per
// clock; each item passes a row of min(TRIG_STAGES, 30) cordic cells
// (one micro-rotation each) followed by five multiply/add stages. The whole pipe
// advances together; it holds only while a result waits on rsp_port.
module axis_angle_vector_rotate_unit #(
   parameter int unsigned TRIG_STAGES = 16
) (
   input logic          clock,
   input logic          reset,
   aavr_req_if.sink     req_port,
   aavr_rsp_if.source   rsp_port
);
   import aavr_pkg::*;

   localparam int unsigned CELLS = (TRIG_STAGES > MAX_CELLS) ? MAX_CELLS : TRIG_STAGES;

   cordic_item_type chain [CELLS+1];
   result_type      result;
   logic            enable;
   logic [15:0]     angle_sum;
   logic [1:0]      quad;
   logic [15:0]     resid;

   // pipe moves when the output register is free or being taken
   assign enable         = !result.valid || rsp_port.ready;
   assign req_port.ready = enable;

   // quadrant and residual angle for the first cell
   always_comb begin
      angle_sum         = req_port.angle + 16'h2000;
      quad              = angle_sum[15:14];
      resid             = req_port.angle - {quad, 14'b0};
      chain[0].valid    = req_port.valid;
      chain[0].quad     = quad;
      chain[0].x        = CORDIC_GAIN;
      chain[0].y        = '0;
      chain[0].z        = {{2{resid[15]}}, resid, 16'b0};
      chain[0].vec      = {req_port.vec_z, req_port.vec_y, req_port.vec_x};
      chain[0].axis     = {req_port.axis_z, req_port.axis_y, req_port.axis_x};
   end

   // row of cordic cells
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      aavr_cordic_cell #(.SHIFT(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   aavr_combine u_combine (
      .clock  (clock),
      .reset  (reset),
      .enable (enable),
      .item   (chain[CELLS]),
      .result (result)
   );

   assign rsp_port.valid = result.valid;
   assign rsp_port.rot_x = result.rot[0];
   assign rsp_port.rot_y = result.rot[1];
   assign rsp_port.rot_z = result.rot[2];
endmodule

[rtl/aavr_checker.sv]
`include "axis_angle_vector_rotate_unit_assert.svh"

module aavr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_rot_x,
   input logic [31:0] rsp_rot_y,
   input logic [31:0] rsp_rot_z
);
   // a stalled result stays offered
   `AAVR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   // and keeps its value
   `AAVR_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_rot_x) && $stable(rsp_rot_y) && $stable(rsp_rot_z))
   // input is ready exactly when the pipe can move
   `AAVR_ASSERT(a_ready_rule, clock, reset, req_ready == (!rsp_valid || rsp_ready))
   // reset empties the pipe
   `AAVR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)
endmodule

bind axis_angle_vector_rotate_unit aavr_checker u_aavr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_port.ready),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .rsp_rot_x (rsp_port.rot_x),
   .rsp_rot_y (rsp_port.rot_y),
   .rsp_rot_z (rsp_port.rot_z)
);

[test/aavr_tb_if.sv]
`timescale 1ns / 1ps
// the rtl interfaces are used as they are; this file only holds helper types
// shared by the stimulus and the checker
package aavr_tb_pkg;

   // one rotation request
   typedef struct {
      logic [31:0] vec_x;
      logic [31:0] vec_y;
      logic [31:0] vec_z;
      logic [31:0] axis_x;
      logic [31:0] axis_y;
      logic [31:0] axis_z;
      logic [15:0] angle;
   } rotate_req_type;

   // one rotated vector
   typedef struct {
      logic [31:0] rot_x;
      logic [31:0] rot_y;
      logic [31:0] rot_z;
   } rotate_rsp_type;

endpackage

[test/axis_angle_vector_rotate_unit_tb.sv]
`timescale 1ns / 1ps
module axis_angle_vector_rotate_unit_tb;
   import aavr_pkg::*;
   import aavr_tb_pkg::*;

   localparam int unsigned STAGES = 16;
   localparam int LATENCY = STAGES + 5;
   localparam int RANDOM_ITEMS = 700;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam longint Q30 = 64'sd1073741824;
   localparam longint INV_GAIN = 64'sd652032874;
   localparam longint MAG = 64'sd4294967295;

   logic clock = 1'b0;
   logic reset = 1'b1;

   aavr_req_if req_port ();
   aavr_rsp_if rsp_port ();

   axis_angle_vector_rotate_unit #(.TRIG_STAGES(STAGES)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_port(req_port.sink),
      .rsp_port(rsp_port.source)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // atan(2^-i) in units of 2^-32 turn
   longint atan_tab [30] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

   // quadrant borders and angle extremes
   logic [15:0] border_angles [12] = '{16'h0000, 16'hFFFF, 16'h1FFF, 16'h2000, 16'h4000,
                                       16'h5FFF, 16'h6000, 16'h8000, 16'hA000, 16'hC000,
                                       16'hDFFF, 16'hE000};

   rotate_rsp_type expected_rot_q[$];
   int errors = 0;
   int sent = 0;
   int received = 0;
   int saturated = 0;
   int idle_cycles = 0;
   bit stim_done = 1'b0;
   bit hold_off = 1'b0;

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // q16.16 times q1.30, operand clamped, rounded half up (>>> floors)
   function automatic longint qmul(longint p, longint w);
      longint pc;
      pc = clamp(p, -MAG, MAG);
      return (pc * w + (64'sd1 <<< 29)) >>> 30;
   endfunction

   // cordic cosine and sine of the angle in q1.30
   function automatic void trig_of(logic [15:0] ang, output longint c, output longint s);
      logic [1:0] quad;
      logic [15:0] resid;
      longint x, y, z, dx, dy;
      int n;
      quad = 2'((17'(ang) + 17'h2000) >> 14);
      resid = ang - {quad, 14'd0};
      z = longint'($signed(resid)) * 65536;
      x = INV_GAIN;
      y = 0;
      n = STAGES > 30 ? 30 : STAGES;
      for (int i = 0; i < n; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - atan_tab[i];
         end else begin
            x = x + dx; y = y - dy; z = z + atan_tab[i];
         end
      end
      case (quad)
         QUAD_0: begin c = x; s = y; end
         QUAD_1: begin c = -y; s = x; end
         QUAD_2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
      c = clamp(c, -Q30, Q30);
      s = clamp(s, -Q30, Q30);
   endfunction

   // rodrigues rotation of one request
   function automatic rotate_rsp_type rotate_vector(rotate_req_type r);
      longint v [3], k [3], cr [3], rot [3];
      longint c, s, d, omc;
      rotate_rsp_type o;
      v[0] = $signed(r.vec_x);  v[1] = $signed(r.vec_y);  v[2] = $signed(r.vec_z);
      k[0] = $signed(r.axis_x); k[1] = $signed(r.axis_y); k[2] = $signed(r.axis_z);
      trig_of(r.angle, c, s);
      cr[0] = qmul(v[2], k[1]) - qmul(v[1], k[2]);
      cr[1] = qmul(v[0], k[2]) - qmul(v[2], k[0]);
      cr[2] = qmul(v[1], k[0]) - qmul(v[0], k[1]);
      d = qmul(v[0], k[0]) + qmul(v[1], k[1]) + qmul(v[2], k[2]);
      omc = Q30 - c;
      for (int j = 0; j < 3; j++) begin
         rot[j] = clamp(qmul(v[j], c) + qmul(cr[j], s) + qmul(qmul(d, k[j]), omc),
                        -64'sd2147483648, 64'sd2147483647);
      end
      o.rot_x = rot[0][31:0];
      o.rot_y = rot[1][31:0];
      o.rot_z = rot[2][31:0];
      return o;
   endfunction

   // gap length: mostly none or short, now and then long
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // random request: small vectors sometimes; unit axes mostly, raw random bits sometimes
   function automatic rotate_req_type random_req();
      rotate_req_type r;
      int mode;
      mode = $urandom_range(0, 9);
      r.vec_x = $urandom;
      r.vec_y = $urandom;
      r.vec_z = $urandom;
      if (mode < 3) begin
         // small vectors, away from saturation
         r.vec_x = 32'($signed(r.vec_x) >>> $urandom_range(4, 14));
         r.vec_y = 32'($signed(r.vec_y) >>> $urandom_range(4, 14));
         r.vec_z = 32'($signed(r.vec_z) >>> $urandom_range(4, 14));
      end
      case ($urandom_range(0, 3))
         0: begin
            r.axis_x = 32'h4000_0000; r.axis_y = 0; r.axis_z = 0;
         end
         1: begin
            r.axis_x = 0; r.axis_y = $urandom_range(0, 1) ? 32'h4000_0000 : 32'hC000_0000;
            r.axis_z = 0;
         end
         2: begin
            // roughly unit diagonal, 1/sqrt(3) in q1.30 with random signs
            r.axis_x = $urandom_range(0, 1) ? 32'd619925131 : -32'd619925131;
            r.axis_y = $urandom_range(0, 1) ? 32'd619925131 : -32'd619925131;
            r.axis_z = $urandom_range(0, 1) ? 32'd619925131 : -32'd619925131;
         end
         default: begin
            r.axis_x = $urandom; r.axis_y = $urandom; r.axis_z = $urandom;
         end
      endcase
      if (mode == 9) begin
         r.axis_x = $urandom; r.axis_y = $urandom; r.axis_z = $urandom;
      end
      r.angle = $urandom;
      return r;
   endfunction

   // directed rows: extremes, quadrant borders, axis corner values
   typedef struct {
      rotate_req_type req;
      bit             known;
      rotate_rsp_type rsp;
   } stim_row_type;

   stim_row_type stim_table [$];

   function automatic stim_row_type mk(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                       logic [31:0] kx, logic [31:0] ky, logic [31:0] kz,
                                       logic [15:0] ang);
      stim_row_type row;
      row.req = '{vx, vy, vz, kx, ky, kz, ang};
      row.known = 1'b0;
      row.rsp = '{0, 0, 0};
      return row;
   endfunction

   function automatic stim_row_type mk_known(logic [31:0] vx, logic [31:0] vy,
                                             logic [31:0] vz, logic [31:0] kx,
                                             logic [31:0] ky, logic [31:0] kz,
                                             logic [15:0] ang, logic [31:0] ex,
                                             logic [31:0] ey, logic [31:0] ez);
      stim_row_type row;
      row = mk(vx, vy, vz, kx, ky, kz, ang);
      row.known = 1'b1;
      row.rsp = '{ex, ey, ez};
      return row;
   endfunction

   initial begin
      // zero vector stays zero for any axis and angle
      stim_table.push_back(mk_known(0, 0, 0, 32'h4000_0000, 0, 0, 16'h1234, 0, 0, 0));
      stim_table.push_back(mk_known(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    16'hFFFF, 0, 0, 0));
      // zero axis: every cross and dot term vanishes
      stim_table.push_back(mk(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 0, 0, 0, 0));
      // quadrant borders and angle extremes
      foreach (border_angles[i]) begin
         stim_table.push_back(mk(32'h0001_0000, 32'h0000_8000, 32'hFFFE_0000,
                                 0, 0, 32'h4000_0000, border_angles[i]));
      end
   end

   // request side
   initial begin
      rotate_req_type r;
      int gap;
      // full scale vectors and over-range axes: inner clamps and output saturation
      stim_table.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000));
      stim_table.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h4000));
      stim_table.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hC000));
      stim_table.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                              32'h4000_0000, 32'h4000_0000, 0, 16'h2000));
      stim_table.push_back(mk(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                              32'hC000_0000, 0, 32'h0000_0001, 16'h0001));

      req_port.valid <= 1'b0;
      req_port.vec_x <= '0; req_port.vec_y <= '0; req_port.vec_z <= '0;
      req_port.axis_x <= '0; req_port.axis_y <= '0; req_port.axis_z <= '0;
      req_port.angle <= '0;
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < stim_table.size() + RANDOM_ITEMS; i++) begin
         r = i < stim_table.size() ? stim_table[i].req : random_req();
         // burst without gaps in the middle of the random part
         gap = (i > 300 && i < 360) ? 0 : gap_len();
         if (gap > 0) begin
            req_port.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_port.valid <= 1'b1;
         req_port.vec_x <= r.vec_x; req_port.vec_y <= r.vec_y; req_port.vec_z <= r.vec_z;
         req_port.axis_x <= r.axis_x; req_port.axis_y <= r.axis_y;
         req_port.axis_z <= r.axis_z; req_port.angle <= r.angle;
         // item is taken at the edge where ready is high
         @(posedge clock iff req_port.ready);
         if (i < stim_table.size() && stim_table[i].known) begin
            expected_rot_q.push_back(stim_table[i].rsp);
         end else begin
            expected_rot_q.push_back(rotate_vector(r));
         end
         sent++;
      end
      req_port.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // long receiver hold-off while requests keep coming
   initial begin
      wait (sent >= 100);
      hold_off = 1'b1;
      repeat (LATENCY * 4) @(posedge clock);
      hold_off = 1'b0;
   end

   // response side with random stalls
   initial begin
      int stall;
      rsp_port.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = (received > 450 && received < 520) ? 0 : gap_len();
         if (stall > 0 || hold_off) begin
            rsp_port.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            while (hold_off) @(posedge clock);
         end
         rsp_port.ready <= 1'b1;
         @(posedge clock iff rsp_port.valid);
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      rotate_rsp_type e;
      if (!reset && rsp_port.valid && rsp_port.ready) begin
         received++;
         if (expected_rot_q.size() == 0) begin
            $error("unexpected result: rot_x %h rot_y %h rot_z %h",
                   rsp_port.rot_x, rsp_port.rot_y, rsp_port.rot_z);
            errors++;
         end else begin
            e = expected_rot_q.pop_front();
            if (e.rot_x == 32'h7FFF_FFFF || e.rot_x == 32'h8000_0000) saturated++;
            if (rsp_port.rot_x !== e.rot_x) begin
               $error("rot_x expected %h actual %h", e.rot_x, rsp_port.rot_x);
               errors++;
            end
            if (rsp_port.rot_y !== e.rot_y) begin
               $error("rot_y expected %h actual %h", e.rot_y, rsp_port.rot_y);
               errors++;
            end
            if (rsp_port.rot_z !== e.rot_z) begin
               $error("rot_z expected %h actual %h", e.rot_z, rsp_port.rot_z);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((req_port.valid && req_port.ready) || (rsp_port.valid && rsp_port.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", expected_rot_q.size());
         $display("FAIL");
         $finish;
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      while (expected_rot_q.size() != 0) @(posedge clock);
      repeat (LATENCY * 2) @(posedge clock);
      $display("rotations sent %0d, results checked %0d, x saturated %0d",
               sent, received, saturated);
      $display("covered quadrant borders, full-scale vectors, non-unit axes, stalls");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
